// ===== sv/mdu_pkg.sv =====
// Shared constants, types and operation codes of the integer multiply/divide unit.
package mdu_pkg;

	localparam int XLEN = 32;

	typedef enum logic [2:0] {
		KIND_MUL    = 3'd0,
		KIND_MULH   = 3'd1,
		KIND_MULHSU = 3'd2,
		KIND_MULHU  = 3'd3,
		KIND_DIV    = 3'd4,
		KIND_DIVU   = 3'd5,
		KIND_REM    = 3'd6,
		KIND_REMU   = 3'd7
	} kind_t;

	typedef struct packed {
		logic is_div;
		logic upper;
		logic neg;
	} ctl_t;

	typedef struct packed {
		ctl_t              ctl;
		logic [XLEN-1:0]   p;
		logic [XLEN-1:0]   x;
		logic [XLEN-1:0]   b;
	} word_t;

endpackage

// ===== sv/mdu_req_if.sv =====
// Request channel of the multiply/divide unit: operation code and two operands.
interface mdu_req_if;
	logic                         valid;
	logic                         ready;
	logic [2:0]                   kind;
	logic [mdu_pkg::XLEN-1:0]     operand_a;
	logic [mdu_pkg::XLEN-1:0]     operand_b;

	modport source (output valid, output kind, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input kind, input operand_a, input operand_b,
		output ready);
endinterface

// ===== sv/mdu_rsp_if.sv =====
// Response channel of the multiply/divide unit: one result word.
interface mdu_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mdu_pkg::XLEN-1:0]     result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

// ===== sv/mdu_prep.sv =====
// Input stage: decodes the operation, takes operand magnitudes and sets the sign fix-up.
module mdu_prep (
	input  logic                clk,
	input  logic                arst_n,
	mdu_req_if.sink             req,
	output logic                next_valid,
	input  logic                next_ready,
	output mdu_pkg::word_t      next_word
);

	mdu_pkg::kind_t               kind;
	logic                         a_sgn;
	logic                         b_sgn;
	logic                         na;
	logic                         nb;
	logic                         upper;
	logic                         is_div;
	logic                         neg;
	logic [mdu_pkg::XLEN-1:0]     ma;
	logic [mdu_pkg::XLEN-1:0]     mb;
	logic                         valid_s1;
	mdu_pkg::word_t               word_s1;
	logic                         take;

	assign kind = mdu_pkg::kind_t'(req.kind);

	always_comb begin
		a_sgn = 1'b0;
		b_sgn = 1'b0;
		upper = 1'b0;
		unique case (kind) inside
			mdu_pkg::KIND_MUL: begin
				a_sgn = 1'b1;
				b_sgn = 1'b1;
				upper = 1'b0;
			end
			mdu_pkg::KIND_MULH, mdu_pkg::KIND_REM: begin
				a_sgn = 1'b1;
				b_sgn = 1'b1;
				upper = 1'b1;
			end
			mdu_pkg::KIND_MULHSU: begin
				a_sgn = 1'b1;
				b_sgn = 1'b0;
				upper = 1'b1;
			end
			mdu_pkg::KIND_MULHU, mdu_pkg::KIND_REMU: begin
				a_sgn = 1'b0;
				b_sgn = 1'b0;
				upper = 1'b1;
			end
			mdu_pkg::KIND_DIV: begin
				a_sgn = 1'b1;
				b_sgn = 1'b1;
				upper = 1'b0;
			end
			mdu_pkg::KIND_DIVU: begin
				a_sgn = 1'b0;
				b_sgn = 1'b0;
				upper = 1'b0;
			end
			default: begin
				a_sgn = 1'b0;
				b_sgn = 1'b0;
				upper = 1'b0;
			end
		endcase
	end

	always_comb begin
		is_div = req.kind[2];
		na = a_sgn & req.operand_a[mdu_pkg::XLEN-1];
		nb = b_sgn & req.operand_b[mdu_pkg::XLEN-1];
		ma = na ? (~req.operand_a + {{(mdu_pkg::XLEN-1){1'b0}}, 1'b1}) : req.operand_a;
		mb = nb ? (~req.operand_b + {{(mdu_pkg::XLEN-1){1'b0}}, 1'b1}) : req.operand_b;
		// A zero divisor keeps an all-ones quotient unsigned and the dividend as remainder.
		if (!is_div) begin
			neg = na ^ nb;
		end else if (upper) begin
			neg = na;
		end else begin
			neg = (na ^ nb) & (req.operand_b != '0);
		end
	end

	assign req.ready = !valid_s1 || next_ready;
	assign take = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1.ctl.is_div <= is_div;
			word_s1.ctl.upper  <= upper;
			word_s1.ctl.neg    <= neg;
			word_s1.p          <= '0;
			word_s1.x          <= ma;
			word_s1.b          <= mb;
		end
	end

	assign next_valid = valid_s1;
	assign next_word  = word_s1;

endmodule

// ===== sv/mdu_cell.sv =====
// One step cell: a shift-and-add multiply step or a restoring divide step on its transaction.
module mdu_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                prev_valid,
	output logic                prev_ready,
	input  mdu_pkg::word_t      prev_word,
	output logic                next_valid,
	input  logic                next_ready,
	output mdu_pkg::word_t      next_word
);

	logic [mdu_pkg::XLEN:0]       sum;
	logic [mdu_pkg::XLEN:0]       sh;
	logic [mdu_pkg::XLEN:0]       diff;
	mdu_pkg::word_t               step;
	logic                         valid_q;
	mdu_pkg::word_t               word_q;

	always_comb begin
		step = prev_word;
		sum  = {1'b0, prev_word.p} + (prev_word.x[0] ? {1'b0, prev_word.b}
			: {(mdu_pkg::XLEN+1){1'b0}});
		sh   = {prev_word.p, prev_word.x[mdu_pkg::XLEN-1]};
		diff = sh - {1'b0, prev_word.b};
		if (!prev_word.ctl.is_div) begin
			step.p = sum[mdu_pkg::XLEN:1];
			step.x = {sum[0], prev_word.x[mdu_pkg::XLEN-1:1]};
		end else if (!diff[mdu_pkg::XLEN]) begin
			step.p = diff[mdu_pkg::XLEN-1:0];
			step.x = {prev_word.x[mdu_pkg::XLEN-2:0], 1'b1};
		end else begin
			step.p = sh[mdu_pkg::XLEN-1:0];
			step.x = {prev_word.x[mdu_pkg::XLEN-2:0], 1'b0};
		end
	end

	assign prev_ready = !valid_q || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (prev_ready) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_valid && prev_ready) begin
			word_q <= step;
		end
	end

	assign next_valid = valid_q;
	assign next_word  = word_q;

endmodule

// ===== sv/mdu_fix.sv =====
// Output stage: applies the sign fix-up, selects the result half and holds the result.
module mdu_fix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                prev_valid,
	output logic                prev_ready,
	input  mdu_pkg::word_t      prev_word,
	mdu_rsp_if.source           rsp
);

	logic [mdu_pkg::XLEN-1:0]     sel;
	logic [mdu_pkg::XLEN-1:0]     res;
	logic                         lo_zero;
	logic                         valid_q;
	logic [mdu_pkg::XLEN-1:0]     result_q;

	always_comb begin
		lo_zero = (prev_word.x == '0);
		sel = prev_word.ctl.upper ? prev_word.p : prev_word.x;
		if (!prev_word.ctl.neg) begin
			res = sel;
		end else if (!prev_word.ctl.is_div && prev_word.ctl.upper) begin
			// High half of a negated double-width product borrows from the low half.
			res = ~prev_word.p + {{(mdu_pkg::XLEN-1){1'b0}}, lo_zero};
		end else begin
			res = ~sel + {{(mdu_pkg::XLEN-1){1'b0}}, 1'b1};
		end
	end

	assign prev_ready = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (prev_ready) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_valid && prev_ready) begin
			result_q <= res;
		end
	end

	assign rsp.valid  = valid_q;
	assign rsp.result = result_q;

endmodule

// ===== sv/integer_mul_div_unit_top.sv =====
// Top level of the pipelined RISC-V M-extension integer multiply/divide unit.
// The unit takes one transaction per cycle unless the result channel holds it off, and
// returns the results in order: one input stage, a row of XLEN step cells
// that each perform one shift-and-add or one restoring-divide step, and one output
// register. Each stage stalls only when the stage after it is full and stalled, so
// bubbles close up while the result channel is held off.
module integer_mul_div_unit_top (
	input  logic                clk,
	input  logic                arst_n,
	mdu_req_if.sink             req,
	mdu_rsp_if.source           rsp
);

	logic [mdu_pkg::XLEN:0]       chain_valid;
	logic [mdu_pkg::XLEN:0]       chain_ready;
	mdu_pkg::word_t               chain_word [mdu_pkg::XLEN+1];

	mdu_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.next_valid (chain_valid[0]),
		.next_ready (chain_ready[0]),
		.next_word  (chain_word[0])
	);

	for (genvar i = 0; i < mdu_pkg::XLEN; i++) begin : g_cell
		mdu_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_valid (chain_valid[i]),
			.prev_ready (chain_ready[i]),
			.prev_word  (chain_word[i]),
			.next_valid (chain_valid[i+1]),
			.next_ready (chain_ready[i+1]),
			.next_word  (chain_word[i+1])
		);
	end

	mdu_fix u_fix (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (chain_valid[mdu_pkg::XLEN]),
		.prev_ready (chain_ready[mdu_pkg::XLEN]),
		.prev_word  (chain_word[mdu_pkg::XLEN]),
		.rsp        (rsp)
	);

endmodule
